[rtl/core/tmp_pkg.sv]
package tmp_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  typedef enum logic [0:0] {
    CMD_TARGET = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MAX_VEL  = 2'd0,
    REG_MAX_ACC  = 2'd1,
    REG_PREC     = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P_ABS,
    S_P_RT,
    S_P_VV,
    S_P_RD,
    S_P_Q,
    S_P_SQ,
    S_P_TC,
    S_T_SEL,
    S_T_SQ,
    S_T_H,
    S_T_LIN,
    S_T_POS,
    S_T_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [63:0] opa;
    logic [31:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [95:0] prod;
    logic [63:0] quot;
    logic [31:0] root;
  } alu_rsp_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (|v[63:32]) ? SAT32 : v[31:0];
  endfunction

endpackage

[rtl/core/tmp_in_if.sv]
interface tmp_in_if;
  logic               valid;
  logic               ready;
  logic [0:0]         cmd;
  logic signed [31:0] new_target;
  logic [18:0]        time_step;

  modport source (output valid, output cmd, output new_target, output time_step,
                  input ready);
  modport sink (input valid, input cmd, input new_target, input time_step,
                output ready);
endinterface

[rtl/core/tmp_out_if.sv]
interface tmp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_setpoint;
  logic               motion_done;

  modport source (output valid, output position_setpoint, output motion_done, input ready);
  modport sink (input valid, input position_setpoint, input motion_done, output ready);
endinterface

[rtl/core/tmp_alu.sv]
module tmp_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  tmp_pkg::alu_req_t  req,
  output tmp_pkg::alu_rsp_t  rsp
);

  logic              busy_r;
  logic              done_r;
  tmp_pkg::op_t      op_r;
  logic [5:0]        cnt_r;
  logic [63:0]       x_r;
  logic [31:0]       y_r;
  logic [95:0]       p_r;
  logic [32:0]       rem_r;

  logic [64:0]       mul_sum;
  logic [32:0]       div_t;
  logic              div_ge;
  logic [34:0]       sq_t;
  logic [34:0]       sq_trial;
  logic              sq_ge;
  logic              last;

  always_comb begin
    mul_sum  = {1'b0, p_r[95:32]} + (y_r[0] ? {1'b0, x_r} : 65'd0);
    div_t    = {rem_r[31:0], x_r[63]};
    div_ge   = div_t >= {1'b0, y_r};
    sq_t     = {rem_r, x_r[63:62]};
    sq_trial = {1'b0, y_r, 2'b01};
    sq_ge    = sq_t >= sq_trial;
    last     = (op_r == tmp_pkg::OP_DIV) ? (cnt_r == 6'd63) : (cnt_r == 6'd31);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (!busy_r) begin
        busy_r <= req.start;
      end else if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      op_r  <= req.op;
      cnt_r <= 6'd0;
      x_r   <= req.opa;
      y_r   <= (req.op == tmp_pkg::OP_SQRT) ? 32'd0 : req.opb;
      p_r   <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      case (op_r)
        tmp_pkg::OP_MUL: begin
          p_r <= {mul_sum, p_r[31:1]};
          y_r <= {1'b0, y_r[31:1]};
        end
        tmp_pkg::OP_DIV: begin
          rem_r <= {1'b0, div_ge ? 32'(div_t - {1'b0, y_r}) : div_t[31:0]};
          x_r   <= {x_r[62:0], div_ge};
        end
        tmp_pkg::OP_SQRT: begin
          rem_r <= sq_ge ? 33'(sq_t - sq_trial) : sq_t[32:0];
          y_r   <= {y_r[30:0], sq_ge};
          x_r   <= {x_r[61:0], 2'b00};
        end
        default: begin
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = p_r;
  assign rsp.quot = x_r;
  assign rsp.root = y_r;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("unit reports done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (req.start && !busy_r) |=> busy_r)
    else $error("unit did not take a start request");
  a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && last) |=> (done_r && !busy_r))
    else $error("unit did not finish after its last step");
`endif

endmodule

[rtl/core/trapezoidal_motion_profile.sv]
// Position setpoint generator for one joint. A target request plans a triangular or
// trapezoidal move from the current position and keeps the input busy while it runs
// three 64-step divisions, one 32-step multiply and, for a triangular move, one 32-step
// square root, all one after another on a single shared shift-and-add unit. A tick
// request runs two 32-step multiplies on that unit on a ramp, one in the cruise phase
// and none at the start or the end of a move, and also waits while the previous setpoint
// is still held at the output. It yields one setpoint while a move is active. The block
// takes one request at a time. Values are Q16.16; a move ends with the exact goal and
// motion_done set.
module trapezoidal_motion_profile (
  input  logic            clk,
  input  logic            rst_n,
  tmp_in_if.sink          in_chan,
  tmp_out_if.source       out_chan,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [30:0]     cfg_wdata
);

  tmp_pkg::state_t    state_r, state_nxt;
  tmp_pkg::alu_req_t  req;
  tmp_pkg::alu_rsp_t  rsp;

  logic [30:0]        vel_r, acc_r;
  logic [15:0]        prec_r;
  logic signed [31:0] cur_r, start_r, goal_r, pos_r;
  logic [31:0]        elapsed_r, dur_r, rt_r, rd_r;
  logic               tri_r, moving_r, dec_r;
  logic [32:0]        absd_r;
  logic [63:0]        off_r;
  logic               out_valid_r, out_done_r;
  logic signed [31:0] out_pos_r;

  logic [30:0]        lim_v, lim_a;
  logic signed [32:0] dgs, dpg;
  logic [32:0]        abs_now, diff;
  logic               in_ready, in_acc, is_tick;
  logic [32:0]        el_sum;
  logic               sel_zero, sel_end, sel_fwd, sel_lin;
  logic [31:0]        harg, tlin;
  logic               is_tri;
  logic [32:0]        diffd;
  logic [62:0]        hval;
  logic [63:0]        offc;
  logic [64:0]        tc_sum;
  logic               fin_done, out_free;

  tmp_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    lim_v    = (vel_r == 31'd0) ? 31'd1 : vel_r;
    lim_a    = (acc_r == 31'd0) ? 31'd1 : acc_r;
    dgs      = {goal_r[31], goal_r} - {start_r[31], start_r};
    abs_now  = dgs[32] ? 33'(-dgs) : 33'(dgs);
    dpg      = {pos_r[31], pos_r} - {goal_r[31], goal_r};
    diff     = dpg[32] ? 33'(-dpg) : 33'(dpg);
    in_ready = (state_r == tmp_pkg::S_IDLE);
    in_acc   = in_chan.valid && in_ready;
    is_tick  = (in_chan.cmd == tmp_pkg::CMD_TICK);
    el_sum   = {1'b0, elapsed_r} + {14'd0, in_chan.time_step};
    sel_zero = (elapsed_r == 32'd0);
    sel_end  = (elapsed_r >= dur_r);
    sel_fwd  = tri_r ? (elapsed_r <= {1'b0, dur_r[31:1]}) : (elapsed_r <= rt_r);
    sel_lin  = !tri_r && !sel_fwd && (dur_r >= rt_r) && (elapsed_r <= dur_r - rt_r);
    harg     = sel_fwd ? elapsed_r : dur_r - elapsed_r;
    tlin     = elapsed_r - rt_r;
    is_tri   = {rsp.quot[62:0], 1'b0} >= {31'd0, absd_r};
    diffd    = absd_r - 33'({rsp.quot[62:0], 1'b0});
    hval     = rsp.prod[95:33];
    offc     = (off_r > {31'd0, absd_r}) ? {31'd0, absd_r} : off_r;
    tc_sum   = {32'd0, rt_r, 1'b0} + {1'b0, rsp.quot};
    fin_done = (elapsed_r >= dur_r) || (diff < {17'd0, prec_r});
    out_free = !out_valid_r || out_chan.ready;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmp_pkg::S_IDLE: begin
        if (in_acc && !is_tick) begin
          state_nxt = tmp_pkg::S_P_ABS;
        end else if (in_acc && moving_r) begin
          state_nxt = tmp_pkg::S_T_SEL;
        end
      end
      tmp_pkg::S_P_ABS: begin
        state_nxt = (abs_now < {17'd0, prec_r}) ? tmp_pkg::S_IDLE : tmp_pkg::S_P_RT;
      end
      tmp_pkg::S_P_RT: if (rsp.done) state_nxt = tmp_pkg::S_P_VV;
      tmp_pkg::S_P_VV: if (rsp.done) state_nxt = tmp_pkg::S_P_RD;
      tmp_pkg::S_P_RD: begin
        if (rsp.done) begin
          state_nxt = is_tri ? tmp_pkg::S_P_Q : tmp_pkg::S_P_TC;
        end
      end
      tmp_pkg::S_P_Q: begin
        if (rsp.done) begin
          state_nxt = (|rsp.quot[63:48]) ? tmp_pkg::S_IDLE : tmp_pkg::S_P_SQ;
        end
      end
      tmp_pkg::S_P_SQ: if (rsp.done) state_nxt = tmp_pkg::S_IDLE;
      tmp_pkg::S_P_TC: if (rsp.done) state_nxt = tmp_pkg::S_IDLE;
      tmp_pkg::S_T_SEL: begin
        if (sel_zero || sel_end) begin
          state_nxt = tmp_pkg::S_T_OUT;
        end else if (sel_lin) begin
          state_nxt = tmp_pkg::S_T_LIN;
        end else begin
          state_nxt = tmp_pkg::S_T_SQ;
        end
      end
      tmp_pkg::S_T_SQ: if (rsp.done) state_nxt = tmp_pkg::S_T_H;
      tmp_pkg::S_T_H: if (rsp.done) state_nxt = tmp_pkg::S_T_POS;
      tmp_pkg::S_T_LIN: if (rsp.done) state_nxt = tmp_pkg::S_T_POS;
      tmp_pkg::S_T_POS: state_nxt = tmp_pkg::S_T_OUT;
      tmp_pkg::S_T_OUT: if (out_free) state_nxt = tmp_pkg::S_IDLE;
      default: state_nxt = tmp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req.start = 1'b0;
    req.op    = tmp_pkg::OP_MUL;
    req.opa   = 64'd0;
    req.opb   = 32'd0;
    unique case (state_r)
      tmp_pkg::S_P_ABS: begin
        req.start = !(abs_now < {17'd0, prec_r});
        req.op    = tmp_pkg::OP_DIV;
        req.opa   = {17'd0, lim_v, 16'd0};
        req.opb   = {1'b0, lim_a};
      end
      tmp_pkg::S_P_RT: begin
        req.start = rsp.done;
        req.opa   = {33'd0, lim_v};
        req.opb   = {1'b0, lim_v};
      end
      tmp_pkg::S_P_VV: begin
        req.start = rsp.done;
        req.op    = tmp_pkg::OP_DIV;
        req.opa   = rsp.prod[63:0];
        req.opb   = {lim_a, 1'b0};
      end
      tmp_pkg::S_P_RD: begin
        req.start = rsp.done;
        req.op    = tmp_pkg::OP_DIV;
        req.opa   = is_tri ? {15'd0, absd_r, 16'd0} : {15'd0, diffd, 16'd0};
        req.opb   = is_tri ? {1'b0, lim_a} : {1'b0, lim_v};
      end
      tmp_pkg::S_P_Q: begin
        req.start = rsp.done && !(|rsp.quot[63:48]);
        req.op    = tmp_pkg::OP_SQRT;
        req.opa   = {rsp.quot[47:0], 16'd0};
      end
      tmp_pkg::S_T_SEL: begin
        req.start = !(sel_zero || sel_end);
        req.opa   = sel_lin ? {33'd0, lim_v} : {32'd0, harg};
        req.opb   = sel_lin ? tlin : harg;
      end
      tmp_pkg::S_T_SQ: begin
        req.start = rsp.done;
        req.opa   = rsp.prod[63:0];
        req.opb   = {1'b0, lim_a};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmp_pkg::S_IDLE;
      vel_r       <= 31'd65536;
      acc_r       <= 31'd65536;
      prec_r      <= 16'd66;
      cur_r       <= '0;
      start_r     <= '0;
      goal_r      <= '0;
      elapsed_r   <= '0;
      dur_r       <= '0;
      rt_r        <= '0;
      rd_r        <= '0;
      tri_r       <= 1'b0;
      moving_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (tmp_pkg::reg_idx_t'(cfg_index))
          tmp_pkg::REG_MAX_VEL: vel_r  <= cfg_wdata;
          tmp_pkg::REG_MAX_ACC: acc_r  <= cfg_wdata;
          tmp_pkg::REG_PREC:    prec_r <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
      if (out_valid_r && out_chan.ready && (state_r != tmp_pkg::S_T_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        tmp_pkg::S_IDLE: begin
          if (in_acc && !is_tick) begin
            goal_r    <= in_chan.new_target;
            start_r   <= cur_r;
            elapsed_r <= '0;
            moving_r  <= 1'b1;
          end else if (in_acc && moving_r) begin
            elapsed_r <= el_sum[32] ? tmp_pkg::SAT32 : el_sum[31:0];
          end
        end
        tmp_pkg::S_P_ABS: begin
          absd_r <= abs_now;
          if (abs_now < {17'd0, prec_r}) begin
            dur_r    <= '0;
            moving_r <= 1'b0;
          end
        end
        tmp_pkg::S_P_RT: if (rsp.done) rt_r <= tmp_pkg::sat32(rsp.quot);
        tmp_pkg::S_P_RD: begin
          if (rsp.done) begin
            rd_r  <= tmp_pkg::sat32(rsp.quot);
            tri_r <= is_tri;
          end
        end
        tmp_pkg::S_P_Q: if (rsp.done && (|rsp.quot[63:48])) dur_r <= tmp_pkg::SAT32;
        tmp_pkg::S_P_SQ: begin
          if (rsp.done) dur_r <= rsp.root[31] ? tmp_pkg::SAT32 : {rsp.root[30:0], 1'b0};
        end
        tmp_pkg::S_P_TC: begin
          if (rsp.done) dur_r <= (|tc_sum[64:32]) ? tmp_pkg::SAT32 : tc_sum[31:0];
        end
        tmp_pkg::S_T_SEL: begin
          dec_r <= !sel_fwd;
          if (sel_zero) begin
            pos_r <= start_r;
          end else if (sel_end) begin
            pos_r <= goal_r;
          end
        end
        tmp_pkg::S_T_H: begin
          if (rsp.done) begin
            if (!dec_r) begin
              off_r <= {1'b0, hval};
            end else begin
              off_r <= ({1'b0, hval} >= {31'd0, absd_r}) ? 64'd0 :
                       64'({31'd0, absd_r} - {1'b0, hval});
            end
          end
        end
        tmp_pkg::S_T_LIN: begin
          if (rsp.done) off_r <= {17'd0, rsp.prod[62:16]} + {32'd0, rd_r};
        end
        tmp_pkg::S_T_POS: begin
          pos_r <= (goal_r > start_r) ? start_r + offc[31:0] : start_r - offc[31:0];
        end
        tmp_pkg::S_T_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pos_r   <= fin_done ? goal_r : pos_r;
            out_done_r  <= fin_done;
            cur_r       <= fin_done ? goal_r : pos_r;
            if (fin_done) moving_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_chan.ready              = in_ready;
  assign out_chan.valid             = out_valid_r;
  assign out_chan.position_setpoint = out_pos_r;
  assign out_chan.motion_done       = out_done_r;

`ifndef SYNTHESIS
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmp_pkg::S_T_OUT && !out_valid_r) |=> out_valid_r)
    else $error("tick result was not loaded");
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_tick && !moving_r) |=> (state_r == tmp_pkg::S_IDLE))
    else $error("tick without a move started work");
  a_busy_plan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmp_pkg::S_P_RT && !rsp.done) |=> (state_r == tmp_pkg::S_P_RT))
    else $error("planning advanced before the division finished");
`endif

endmodule

[tb/sv/trapezoidal_motion_profile_tb.sv]
module trapezoidal_motion_profile_tb;

  typedef struct {
    tmp_pkg::cmd_t cmd;
    logic [31:0]   target;
    logic [18:0]   step;
  } request_t;

  typedef struct {
    logic [31:0] pos;
    logic        done;
  } setpoint_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_wdata;

  tmp_in_if  in_if();
  tmp_out_if out_if();

  trapezoidal_motion_profile uut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if), .out_chan(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  request_t  request_q[$];
  setpoint_t setpoint_q[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      request_taken = 1'b0;

  logic [31:0] lim_vel, lim_acc, lim_prec;
  logic signed [31:0] cur_pos, start_pos, goal_pos;
  logic [31:0] elapsed_t, dur_t, ramp_t, ramp_d;
  logic        tri_shape, in_motion;

  function automatic logic [31:0] clip32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [63:0] mul_clip(input logic [63:0] x, input logic [63:0] y,
                                          input int sh);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    p = p >> sh;
    return (|p[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] vel_used();
    return (lim_vel != 0) ? {32'd0, lim_vel} : 64'd1;
  endfunction

  function automatic logic [63:0] acc_used();
    return (lim_acc != 0) ? {32'd0, lim_acc} : 64'd1;
  endfunction

  function automatic logic [63:0] move_length();
    logic signed [63:0] d;
    d = 64'(goal_pos) - 64'(start_pos);
    return (d < 0) ? -d : d;
  endfunction

  function automatic logic [63:0] ramp_offset(input logic [63:0] t);
    return mul_clip(acc_used(), mul_clip(t, t, 0), 2 * tmp_pkg::FRAC_BITS + 1);
  endfunction

  task automatic plan_move();
    logic [63:0] v, a, span, rd, q, th, tc;
    v = vel_used();
    a = acc_used();
    span = move_length();
    if (span < lim_prec) begin
      dur_t = 0;
      in_motion = 1'b0;
    end else begin
      ramp_t = clip32((v << tmp_pkg::FRAC_BITS) / a);
      rd = (v * v) / (2 * a);
      ramp_d = clip32(rd);
      if (2 * rd >= span) begin
        q = (span << tmp_pkg::FRAC_BITS) / a;
        tri_shape = 1'b1;
        if (q > (64'hFFFF_FFFF_FFFF_FFFF >> tmp_pkg::FRAC_BITS)) th = 64'hFFFF_FFFF;
        else th = clip32(int_sqrt(q << tmp_pkg::FRAC_BITS));
        dur_t = clip32(2 * th);
      end else begin
        tc = ((span - 2 * rd) << tmp_pkg::FRAC_BITS) / v;
        tri_shape = 1'b0;
        dur_t = clip32(2 * {32'd0, ramp_t} + tc);
      end
    end
  endtask

  function automatic logic [31:0] position_at(input logic [31:0] t);
    logic [63:0] span, off, dec;
    logic signed [63:0] pos;
    span = move_length();
    if (t == 0) return start_pos;
    if (t >= dur_t) return goal_pos;
    if (tri_shape) begin
      if (t <= dur_t / 2) begin
        off = ramp_offset(t);
      end else begin
        dec = ramp_offset(dur_t - t);
        off = (dec >= span) ? 0 : span - dec;
      end
    end else if (t <= ramp_t) begin
      off = ramp_offset(t);
    end else if (dur_t >= ramp_t && t <= dur_t - ramp_t) begin
      off = mul_clip(vel_used(), {32'd0, t - ramp_t}, tmp_pkg::FRAC_BITS);
      off = (off > 64'hFFFF_FFFF_FFFF_FFFF - ramp_d) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                       : off + ramp_d;
    end else begin
      dec = ramp_offset(dur_t - t);
      off = (dec >= span) ? 0 : span - dec;
    end
    if (off > span) off = span;
    if (goal_pos > start_pos) pos = 64'(start_pos) + $signed(off);
    else pos = 64'(start_pos) - $signed(off);
    return pos[31:0];
  endfunction

  task automatic predict_request(input request_t r);
    setpoint_t sp;
    logic signed [63:0] d;
    if (r.cmd == tmp_pkg::CMD_TARGET) begin
      goal_pos = r.target;
      start_pos = cur_pos;
      elapsed_t = 0;
      in_motion = 1'b1;
      plan_move();
    end else if (in_motion) begin
      elapsed_t = clip32({32'd0, elapsed_t} + r.step);
      cur_pos = position_at(elapsed_t);
      d = 64'(cur_pos) - 64'(goal_pos);
      if (d < 0) d = -d;
      sp.done = (elapsed_t >= dur_t) || (d < lim_prec);
      if (sp.done) begin
        cur_pos = goal_pos;
        in_motion = 1'b0;
      end
      sp.pos = cur_pos;
      setpoint_q.push_back(sp);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("trapezoidal_motion_profile_tb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    request_t  r;
    setpoint_t sp;
    if (!rst_n) begin
      lim_vel = 65536; lim_acc = 65536; lim_prec = 66;
      cur_pos = 0; start_pos = 0; goal_pos = 0;
      elapsed_t = 0; dur_t = 0; ramp_t = 0; ramp_d = 0;
      tri_shape = 1'b0; in_motion = 1'b0;
      request_taken <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tmp_pkg::REG_MAX_VEL: lim_vel = {1'b0, cfg_wdata};
          tmp_pkg::REG_MAX_ACC: lim_acc = {1'b0, cfg_wdata};
          tmp_pkg::REG_PREC:    lim_prec = {16'd0, cfg_wdata[15:0]};
          default: ;
        endcase
      end
      request_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        r.cmd = tmp_pkg::cmd_t'(in_if.cmd);
        r.target = in_if.new_target;
        r.step = in_if.time_step;
        predict_request(r);
      end
      if (out_if.valid && out_if.ready) begin
        if (setpoint_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected setpoint %h done %b", $time,
                   out_if.position_setpoint, out_if.motion_done);
        end else begin
          sp = setpoint_q.pop_front();
          if (out_if.position_setpoint !== sp.pos) begin
            errors++;
            $display("%0t: position_setpoint expected %h actual %h", $time, sp.pos,
                     out_if.position_setpoint);
          end
          if (out_if.motion_done !== sp.done) begin
            errors++;
            $display("%0t: motion_done expected %b actual %b", $time, sp.done,
                     out_if.motion_done);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    request_t r;
    if (rst_n && (!in_if.valid || request_taken)) begin
      if (request_q.size() == 0 || $urandom_range(99) < send_idle_pct) begin
        in_if.valid <= 1'b0;
      end else begin
        r = request_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.cmd <= r.cmd;
        in_if.new_target <= r.target;
        in_if.time_step <= r.step;
      end
    end
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic push_request(input tmp_pkg::cmd_t c, input logic [31:0] tgt,
                              input logic [18:0] st);
    request_t r;
    r.cmd = c;
    r.target = tgt;
    r.step = st;
    request_q.push_back(r);
  endtask

  task automatic drain();
    while (request_q.size() != 0 || in_if.valid || setpoint_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input tmp_pkg::reg_idx_t idx, input logic [30:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic add_random_moves(input int count);
    logic [31:0] tgt, last_tgt;
    int n, k;
    last_tgt = 0;
    k = 0;
    while (k < count) begin
      case ($urandom_range(9))
        0, 1, 2, 3: tgt = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        4, 5:       tgt = $urandom;
        6:          tgt = last_tgt + $urandom_range(0, 400) - 200;
        default:    tgt = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      endcase
      last_tgt = tgt;
      push_request(tmp_pkg::CMD_TARGET, tgt, 19'($urandom));
      n = $urandom_range(1, 12);
      k += n + 1;
      repeat (n) begin
        if ($urandom_range(3) == 0) begin
          push_request(tmp_pkg::CMD_TICK, $urandom, 19'($urandom_range(0, 262144)));
        end else begin
          push_request(tmp_pkg::CMD_TICK, $urandom, 19'($urandom_range(0, 32768)));
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.cmd = tmp_pkg::CMD_TARGET;
    in_if.new_target = '0;
    in_if.time_step = '0;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      repeat (400) @(posedge clk);
      send_idle_pct = (phase == 1) ? 82 : (phase == 3) ? 19 : 0;
      recv_stall_pct = (phase == 2) ? 82 : (phase == 3) ? 19 : 0;
      case (phase)
        0: begin
          write_reg(tmp_pkg::REG_MAX_VEL, 31'd65536);
          write_reg(tmp_pkg::REG_MAX_ACC, 31'd65536);
          write_reg(tmp_pkg::REG_PREC, 31'd66);
        end
        1: begin
          write_reg(tmp_pkg::REG_MAX_VEL, 31'h7FFF_FFFF);
          write_reg(tmp_pkg::REG_MAX_ACC, 31'h7FFF_FFFF);
          write_reg(tmp_pkg::REG_PREC, 31'h7FFF_FFFF);
        end
        2: begin
          write_reg(tmp_pkg::REG_MAX_VEL, 31'd0);
          write_reg(tmp_pkg::REG_MAX_ACC, 31'd0);
          write_reg(tmp_pkg::REG_PREC, 31'd0);
          write_reg(tmp_pkg::reg_idx_t'(2'd3), 31'h1234_5678);
        end
        default: begin
          write_reg(tmp_pkg::REG_MAX_VEL, 31'($urandom_range(1 << 12, 1 << 24)));
          write_reg(tmp_pkg::REG_MAX_ACC, 31'($urandom_range(1 << 12, 1 << 24)));
          write_reg(tmp_pkg::REG_PREC, 31'($urandom_range(0, 2000)));
        end
      endcase
      @(negedge clk);
      cfg_we <= 1'b0;
      if (phase == 0) begin
        push_request(tmp_pkg::CMD_TICK, 32'd0, 19'd65536);
        push_request(tmp_pkg::CMD_TARGET, 32'd10, 19'd0);
        push_request(tmp_pkg::CMD_TICK, 32'd0, 19'd65536);
        push_request(tmp_pkg::CMD_TARGET, 32'h0003_0000, 19'h7FFFF);
        push_request(tmp_pkg::CMD_TICK, 32'd0, 19'd0);
        push_request(tmp_pkg::CMD_TICK, 32'd0, 19'd262143);
        push_request(tmp_pkg::CMD_TICK, 32'd0, 19'd262144);
        push_request(tmp_pkg::CMD_TARGET, 32'h0010_0000, 19'd0);
        repeat (5) push_request(tmp_pkg::CMD_TICK, 32'hFFFF_FFFF, 19'd131072);
        push_request(tmp_pkg::CMD_TARGET, 32'h8000_0000, 19'd0);
        repeat (3) push_request(tmp_pkg::CMD_TICK, 32'd0, 19'd262144);
        push_request(tmp_pkg::CMD_TARGET, 32'h7FFF_FFFF, 19'd0);
        repeat (3) push_request(tmp_pkg::CMD_TICK, 32'd0, 19'd262144);
        push_request(tmp_pkg::CMD_TARGET, 32'h7FFF_FFF0, 19'd0);
        push_request(tmp_pkg::CMD_TICK, 32'd0, 19'd1);
      end
      add_random_moves(50);
      drain();
      add_random_moves(50);
    end
    drain();
    repeat (400) @(posedge clk);
    if (errors == 0 && setpoint_q.size() == 0) begin
      $display("trapezoidal_motion_profile_tb OK");
    end else begin
      $display("trapezoidal_motion_profile_tb NOT OK");
    end
    $finish;
  end

endmodule
